FILE: rtl/mtem_pkg.sv
// Shared types, event codes and helpers for the multitouch event merger.
// No dependencies; used by every module of the block except mtem_ram.
`default_nettype none

package mtem_pkg;

   // Default sizes
   localparam int TotalSlotsDefault   = 16;
   localparam int InjectDepthDefault  = 32;
   localparam int RealDepthDefault    = 16;
   localparam int TrackingBaseDefault = 6000;

   // Request op codes
   localparam logic [2:0] OP_REAL   = 3'd0;
   localparam logic [2:0] OP_DOWN   = 3'd1;
   localparam logic [2:0] OP_MOVE   = 3'd2;
   localparam logic [2:0] OP_UP     = 3'd3;
   localparam logic [2:0] OP_SUBMIT = 3'd4;

   // Event types and codes
   localparam logic [4:0] EV_SYN    = 5'd0;
   localparam logic [4:0] EV_ABS    = 5'd3;
   localparam logic [9:0] C_REPORT  = 10'd0;
   localparam logic [9:0] C_SLOT    = 10'd47;
   localparam logic [9:0] C_TRACK   = 10'd57;
   localparam logic [9:0] C_PX      = 10'd53;
   localparam logic [9:0] C_PY      = 10'd54;

   // Cache entry kinds
   localparam logic [1:0] KIND_SLOT  = 2'd0;
   localparam logic [1:0] KIND_TRACK = 2'd1;
   localparam logic [1:0] KIND_PX    = 2'd2;
   localparam logic [1:0] KIND_PY    = 2'd3;

   localparam int InjWidth  = 34;  // {kind, value}
   localparam int RealWidth = 47;  // {type, code, value}

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH,
      ST_FLUSH,
      ST_TAIL
   } state_type;

   typedef struct packed {
      logic [4:0]  out_type;
      logic [9:0]  out_code;
      logic [31:0] out_value;
      logic        last_of_run;
      logic        dropped_flag;
   } rsp_item_type;

   function automatic logic [9:0] kind_code(input logic [1:0] kind);
      logic [9:0] code;
      case (kind)
         KIND_SLOT:  code = C_SLOT;
         KIND_TRACK: code = C_TRACK;
         KIND_PX:    code = C_PX;
         KIND_PY:    code = C_PY;
         default:    code = C_SLOT;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/multitouch_event_merger_core.sv
// Top level of the multitouch event merger: control, slot state, two buffers.
// Depends on mtem_pkg, mtem_ram and mtem_out_reg.
`default_nettype none

// Merges real device events and injected virtual-finger commands into one
// protocol B event stream. For real events (op 0), absolute-axis events while
// the real slot is above forward_slot_limit are dropped, others go into the
// real frame buffer, and a sync report flushes the buffer followed by the
// report itself. Down, move and up (ops 1-3) address virtual slot
// forward_slot_limit + 1 + slot and write their slot-select, tracking-id and
// position events into the inject cache one entry per cycle. Submit (op 4)
// drains the cache and appends sync, real-slot restore and sync. Both buffers
// are simple dual-port RAMs with a registered read; a flush puts out one result
// per cycle while rsp_ready stays high, and the block takes no new request
// until the last result of the flush is in the output register. A full buffer
// drops events and flags every result of the next flush of that buffer.
// The buffers need no clearing pass after reset: entries are only read below
// their fill count. forward_slot_limit is written through csr_wr_en /
// csr_wr_data and must only change while the block is idle.

module multitouch_event_merger_core #(
   parameter int TOTAL_SLOTS   = mtem_pkg::TotalSlotsDefault,
   parameter int INJECT_DEPTH  = mtem_pkg::InjectDepthDefault,
   parameter int REAL_DEPTH    = mtem_pkg::RealDepthDefault,
   parameter int TRACKING_BASE = mtem_pkg::TrackingBaseDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_op,
   input  wire logic [3:0]         req_slot,
   input  wire logic [15:0]        req_x_pos,
   input  wire logic [15:0]        req_y_pos,
   input  wire logic [4:0]         req_ev_type,
   input  wire logic [9:0]         req_ev_code,
   input  wire logic signed [31:0] req_ev_value,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [4:0]              rsp_out_type,
   output logic [9:0]              rsp_out_code,
   output logic signed [31:0]      rsp_out_value,
   output logic                    rsp_last_of_run,
   output logic                    rsp_dropped_flag,
   // configuration
   input  wire logic               csr_wr_en,
   input  wire logic [3:0]         csr_wr_data
);

   localparam int SLOT_W = $clog2(TOTAL_SLOTS);
   localparam int SEL_W  = (SLOT_W > 5) ? SLOT_W : 5;
   localparam int IA_W   = $clog2(INJECT_DEPTH);
   localparam int RA_W   = $clog2(REAL_DEPTH);
   localparam int IC_W   = $clog2(INJECT_DEPTH + 1);
   localparam int RC_W   = $clog2(REAL_DEPTH + 1);
   localparam int FL_W   = (IC_W > RC_W) ? IC_W : RC_W;

   // tail steps of a submit flush
   localparam logic [1:0] TAIL_SYNC0   = 2'd0;
   localparam logic [1:0] TAIL_RESTORE = 2'd1;
   localparam logic [1:0] TAIL_SYNC1   = 2'd2;

   // ---------------- state ----------------
   mtem_pkg::state_type     state_ff, state_in;
   logic [3:0]              limit_ff;
   logic [TOTAL_SLOTS-1:0]  mask_ff, mask_in;
   logic                    sel_valid_ff, sel_valid_in;   // cache slot select, invalid = none
   logic [SEL_W-1:0]        sel_ff, sel_in;
   logic [31:0]             real_slot_ff, real_slot_in;
   logic [IC_W-1:0]         inj_count_ff, inj_count_in;
   logic [RC_W-1:0]         real_count_ff, real_count_in;
   logic [1:0]              ovf_ff, ovf_in;                // [0] inject, [1] real

   // per-item working registers
   logic [3:0]              plan_ff, plan_in;              // cache kinds still to write
   logic                    up_ff, up_in;
   logic [4:0]              sl_ff, sl_in;
   logic [15:0]             x_ff, x_in;
   logic [15:0]             y_ff, y_in;
   logic [31:0]             tail_val_ff, tail_val_in;
   logic                    src_inj_ff, src_inj_in;
   logic                    drop_ff, drop_in;
   logic [FL_W-1:0]         len_ff, len_in;
   logic [FL_W-1:0]         idx_ff, idx_in;
   logic [1:0]              tail_idx_ff, tail_idx_in;

   // ---------------- memory ports ----------------
   logic                    inj_we, inj_re;
   logic [IA_W-1:0]         inj_waddr, inj_raddr;
   logic [mtem_pkg::InjWidth-1:0]  inj_wdata, inj_rdata;
   logic                    real_we, real_re;
   logic [RA_W-1:0]         real_waddr, real_raddr;
   logic [mtem_pkg::RealWidth-1:0] real_wdata, real_rdata;

   // ---------------- output side ----------------
   logic                    out_push;
   logic                    out_free;
   mtem_pkg::rsp_item_type  out_item;

   // ---------------- decode helpers ----------------
   logic                    accept;
   logic [4:0]              sl_c;
   logic                    sl_ok;
   logic [SLOT_W-1:0]       sl_idx;
   logic                    finger_is_down;
   logic                    sel_match;
   logic [31:0]             new_slot;
   logic                    is_report;
   logic                    keep_real;
   logic [1:0]              kind;
   logic [31:0]             kind_val;
   logic [FL_W-1:0]         idx_next;

   assign req_ready = (state_ff == mtem_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign sl_c      = {1'b0, limit_ff} + {1'b0, req_slot} + 5'd1;
   assign sl_ok     = ({2'b00, sl_c} < 7'(TOTAL_SLOTS));
   assign sl_idx    = SLOT_W'(sl_c);
   assign finger_is_down = sl_ok && mask_ff[sl_idx];
   assign sel_match = sel_valid_ff && (sel_ff == SEL_W'(sl_c));

   assign is_report = (req_ev_type == mtem_pkg::EV_SYN) && (req_ev_code == mtem_pkg::C_REPORT);
   assign new_slot  = ((req_ev_type == mtem_pkg::EV_ABS) && (req_ev_code == mtem_pkg::C_SLOT))
                      ? req_ev_value : real_slot_ff;
   // axis events of a real slot above the limit are not forwarded
   assign keep_real = !((req_ev_type == mtem_pkg::EV_ABS)
                        && ($signed(new_slot) > $signed({28'd0, limit_ff})));

   assign idx_next  = idx_ff + FL_W'(1);

   // next cache kind: lowest pending bit of the plan
   always_comb begin
      if (plan_ff[0]) begin
         kind = mtem_pkg::KIND_SLOT;
      end else if (plan_ff[1]) begin
         kind = mtem_pkg::KIND_TRACK;
      end else if (plan_ff[2]) begin
         kind = mtem_pkg::KIND_PX;
      end else begin
         kind = mtem_pkg::KIND_PY;
      end
   end

   always_comb begin
      case (kind)
         mtem_pkg::KIND_SLOT:  kind_val = {27'd0, sl_ff};
         mtem_pkg::KIND_TRACK: kind_val = up_ff ? 32'hFFFF_FFFF
                                                : 32'(TRACKING_BASE) + {27'd0, sl_ff};
         mtem_pkg::KIND_PX:    kind_val = {16'd0, x_ff};
         mtem_pkg::KIND_PY:    kind_val = {16'd0, y_ff};
         default:              kind_val = {27'd0, sl_ff};
      endcase
   end

   // ---------------- control ----------------
   always_comb begin
      state_in      = state_ff;
      mask_in       = mask_ff;
      sel_valid_in  = sel_valid_ff;
      sel_in        = sel_ff;
      real_slot_in  = real_slot_ff;
      inj_count_in  = inj_count_ff;
      real_count_in = real_count_ff;
      ovf_in        = ovf_ff;
      plan_in       = plan_ff;
      up_in         = up_ff;
      sl_in         = sl_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      tail_val_in   = tail_val_ff;
      src_inj_in    = src_inj_ff;
      drop_in       = drop_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      tail_idx_in   = tail_idx_ff;

      inj_we     = 1'b0;
      inj_waddr  = IA_W'(inj_count_ff);
      inj_wdata  = {kind, kind_val};
      inj_re     = 1'b0;
      inj_raddr  = IA_W'(idx_ff);
      real_we    = 1'b0;
      real_waddr = RA_W'(real_count_ff);
      real_wdata = {req_ev_type, req_ev_code, req_ev_value};
      real_re    = 1'b0;
      real_raddr = RA_W'(idx_ff);

      out_push = 1'b0;
      out_item = '0;

      case (state_ff)
         mtem_pkg::ST_IDLE: begin
            if (accept) begin
               sl_in       = sl_c;
               x_in        = req_x_pos;
               y_in        = req_y_pos;
               tail_val_in = req_ev_value;
               idx_in      = '0;
               tail_idx_in = TAIL_SYNC0;
               case (req_op)
                  mtem_pkg::OP_REAL: begin
                     real_slot_in = new_slot;
                     if (is_report) begin
                        drop_in       = ovf_ff[1];
                        ovf_in[1]     = 1'b0;
                        src_inj_in    = 1'b0;
                        len_in        = FL_W'(real_count_ff);
                        real_count_in = '0;
                        if (real_count_ff != '0) begin
                           real_re    = 1'b1;
                           real_raddr = '0;
                           state_in   = mtem_pkg::ST_FLUSH;
                        end else begin
                           state_in   = mtem_pkg::ST_TAIL;
                        end
                     end else if (keep_real || (req_ev_type == mtem_pkg::EV_SYN)) begin
                        if (real_count_ff >= RC_W'(REAL_DEPTH)) begin
                           ovf_in[1] = 1'b1;
                        end else begin
                           real_we       = 1'b1;
                           real_count_in = real_count_ff + RC_W'(1);
                        end
                     end
                  end
                  mtem_pkg::OP_SUBMIT: begin
                     if (inj_count_ff != '0) begin
                        drop_in      = ovf_ff[0];
                        ovf_in[0]    = 1'b0;
                        src_inj_in   = 1'b1;
                        len_in       = FL_W'(inj_count_ff);
                        inj_count_in = '0;
                        inj_re       = 1'b1;
                        inj_raddr    = '0;
                        state_in     = mtem_pkg::ST_FLUSH;
                        // selection falls back to the real slot
                        sel_valid_in = !real_slot_ff[31]
                                       && (real_slot_ff < 32'(TOTAL_SLOTS));
                        sel_in       = SEL_W'(real_slot_ff);
                     end
                  end
                  mtem_pkg::OP_DOWN: begin
                     if (sl_ok && !finger_is_down) begin
                        plan_in         = 4'b1111;
                        up_in           = 1'b0;
                        sel_valid_in    = 1'b1;
                        sel_in          = SEL_W'(sl_c);
                        mask_in[sl_idx] = 1'b1;
                        state_in        = mtem_pkg::ST_PUSH;
                     end
                  end
                  mtem_pkg::OP_MOVE: begin
                     if (finger_is_down) begin
                        plan_in      = {2'b11, 1'b0, !sel_match};
                        up_in        = 1'b0;
                        sel_valid_in = 1'b1;
                        sel_in       = SEL_W'(sl_c);
                        state_in     = mtem_pkg::ST_PUSH;
                     end
                  end
                  mtem_pkg::OP_UP: begin
                     if (finger_is_down) begin
                        plan_in         = {2'b00, 1'b1, !sel_match};
                        up_in           = 1'b1;
                        sel_valid_in    = 1'b0;
                        mask_in[sl_idx] = 1'b0;
                        state_in        = mtem_pkg::ST_PUSH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         mtem_pkg::ST_PUSH: begin
            // one cache entry per cycle; a full cache drops it
            if (inj_count_ff >= IC_W'(INJECT_DEPTH)) begin
               ovf_in[0] = 1'b1;
            end else begin
               inj_we       = 1'b1;
               inj_count_in = inj_count_ff + IC_W'(1);
            end
            plan_in = plan_ff & (plan_ff - 4'd1);
            if ((plan_ff & (plan_ff - 4'd1)) == 4'd0) begin
               state_in = mtem_pkg::ST_IDLE;
            end
         end

         mtem_pkg::ST_FLUSH: begin
            // read data of entry idx is valid; next read overlaps the transfer
            if (out_free) begin
               out_push = 1'b1;
               if (src_inj_ff) begin
                  out_item.out_type  = mtem_pkg::EV_ABS;
                  out_item.out_code  = mtem_pkg::kind_code(inj_rdata[33:32]);
                  out_item.out_value = inj_rdata[31:0];
               end else begin
                  out_item.out_type  = real_rdata[46:42];
                  out_item.out_code  = real_rdata[41:32];
                  out_item.out_value = real_rdata[31:0];
               end
               out_item.dropped_flag = drop_ff;
               if (idx_next < len_ff) begin
                  idx_in     = idx_next;
                  inj_re     = src_inj_ff;
                  inj_raddr  = IA_W'(idx_next);
                  real_re    = !src_inj_ff;
                  real_raddr = RA_W'(idx_next);
               end else begin
                  state_in = mtem_pkg::ST_TAIL;
               end
            end
         end

         mtem_pkg::ST_TAIL: begin
            if (out_free) begin
               out_push              = 1'b1;
               out_item.dropped_flag = drop_ff;
               tail_idx_in           = tail_idx_ff + 2'd1;
               if (!src_inj_ff) begin
                  out_item.out_type    = mtem_pkg::EV_SYN;
                  out_item.out_code    = mtem_pkg::C_REPORT;
                  out_item.out_value   = tail_val_ff;
                  out_item.last_of_run = 1'b1;
                  state_in             = mtem_pkg::ST_IDLE;
               end else begin
                  case (tail_idx_ff)
                     TAIL_RESTORE: begin
                        out_item.out_type  = mtem_pkg::EV_ABS;
                        out_item.out_code  = mtem_pkg::C_SLOT;
                        out_item.out_value = real_slot_ff;
                     end
                     TAIL_SYNC1: begin
                        out_item.out_type    = mtem_pkg::EV_SYN;
                        out_item.out_code    = mtem_pkg::C_REPORT;
                        out_item.last_of_run = 1'b1;
                        state_in             = mtem_pkg::ST_IDLE;
                     end
                     default: begin
                        out_item.out_type = mtem_pkg::EV_SYN;
                        out_item.out_code = mtem_pkg::C_REPORT;
                     end
                  endcase
               end
            end
         end

         default: begin
            state_in = mtem_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mtem_pkg::ST_IDLE;
         limit_ff      <= 4'd0;
         mask_ff       <= '0;
         sel_valid_ff  <= 1'b0;
         sel_ff        <= '0;
         real_slot_ff  <= 32'd0;
         inj_count_ff  <= '0;
         real_count_ff <= '0;
         ovf_ff        <= 2'b00;
         plan_ff       <= 4'd0;
      end else begin
         state_ff      <= state_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         mask_ff       <= mask_in;
         sel_valid_ff  <= sel_valid_in;
         sel_ff        <= sel_in;
         real_slot_ff  <= real_slot_in;
         inj_count_ff  <= inj_count_in;
         real_count_ff <= real_count_in;
         ovf_ff        <= ovf_in;
         plan_ff       <= plan_in;
      end
   end

   // working payload, no reset
   always_ff @(posedge clock) begin
      up_ff       <= up_in;
      sl_ff       <= sl_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      tail_val_ff <= tail_val_in;
      src_inj_ff  <= src_inj_in;
      drop_ff     <= drop_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      tail_idx_ff <= tail_idx_in;
   end

   // ---------------- buffers ----------------
   // Writes happen only in IDLE/PUSH and reads only at the start of or in FLUSH,
   // never beside a write, so the same entry is never written and read in one cycle.
   mtem_ram #(
      .WIDTH (mtem_pkg::InjWidth),
      .DEPTH (INJECT_DEPTH)
   ) u_inj_ram (
      .clock   (clock),
      .wr_en   (inj_we),
      .wr_addr (inj_waddr),
      .wr_data (inj_wdata),
      .rd_en   (inj_re),
      .rd_addr (inj_raddr),
      .rd_data (inj_rdata)
   );

   mtem_ram #(
      .WIDTH (mtem_pkg::RealWidth),
      .DEPTH (REAL_DEPTH)
   ) u_real_ram (
      .clock   (clock),
      .wr_en   (real_we),
      .wr_addr (real_waddr),
      .wr_data (real_wdata),
      .rd_en   (real_re),
      .rd_addr (real_raddr),
      .rd_data (real_rdata)
   );

   // ---------------- result register ----------------
   mtem_out_reg u_out (
      .clock            (clock),
      .reset            (reset),
      .push             (out_push),
      .item             (out_item),
      .free             (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_type     (rsp_out_type),
      .rsp_out_code     (rsp_out_code),
      .rsp_out_value    (rsp_out_value),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_dropped_flag (rsp_dropped_flag)
   );

endmodule

`default_nettype wire

FILE: rtl/mtem_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing; holds the injected cache and the real frame buffer.
`default_nettype none

module mtem_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/mtem_out_reg.sv
// Output register for the result channel; decouples flushes from rsp_ready.
// Depends on mtem_pkg (rsp_item_type).
`default_nettype none

module mtem_out_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire mtem_pkg::rsp_item_type item,
   output logic                       free,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [4:0]                 rsp_out_type,
   output logic [9:0]                 rsp_out_code,
   output logic signed [31:0]         rsp_out_value,
   output logic                       rsp_last_of_run,
   output logic                       rsp_dropped_flag
);

   logic                  valid_ff;
   logic                  valid_in;
   mtem_pkg::rsp_item_type item_ff;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff <= item;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_type     = item_ff.out_type;
   assign rsp_out_code     = item_ff.out_code;
   assign rsp_out_value    = $signed(item_ff.out_value);
   assign rsp_last_of_run  = item_ff.last_of_run;
   assign rsp_dropped_flag = item_ff.dropped_flag;

endmodule

`default_nettype wire

FILE: rtl/mtem_checker.sv
// Port-level checks for the multitouch event merger, bound to the top level.
// Depends on mtem_pkg and multitouch_event_merger_core.
`default_nettype none

module mtem_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic [2:0]         req_op,
   input wire logic [4:0]         req_ev_type,
   input wire logic [9:0]         req_ev_code,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [4:0]         rsp_out_type,
   input wire logic [9:0]         rsp_out_code,
   input wire logic signed [31:0] rsp_out_value,
   input wire logic               rsp_last_of_run,
   input wire logic               rsp_dropped_flag
);

   // a waiting result is held until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_type) && $stable(rsp_out_code)
                                 && $stable(rsp_out_value) && $stable(rsp_last_of_run)
                                 && $stable(rsp_dropped_flag))
      else $error("result payload changed while stalled");

   // every flush ends on a sync report
   a_last_is_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |-> rsp_out_type == mtem_pkg::EV_SYN
                                      && rsp_out_code == mtem_pkg::C_REPORT)
      else $error("flush does not end on a sync report");

   // a real sync report always starts a flush
   a_report_flushes: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == mtem_pkg::OP_REAL
      && req_ev_type == mtem_pkg::EV_SYN && req_ev_code == mtem_pkg::C_REPORT
      |=> !req_ready)
      else $error("sync report accepted without a flush");

endmodule

bind multitouch_event_merger_core mtem_checker u_mtem_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_op           (req_op),
   .req_ev_type      (req_ev_type),
   .req_ev_code      (req_ev_code),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_type     (rsp_out_type),
   .rsp_out_code     (rsp_out_code),
   .rsp_out_value    (rsp_out_value),
   .rsp_last_of_run  (rsp_last_of_run),
   .rsp_dropped_flag (rsp_dropped_flag)
);

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for multitouch_event_merger_core: directed and random touch traffic,
// results checked in order against a behavioral predictor. Needs mtem_pkg and the RTL.

module tb_top;
   import mtem_pkg::*;

   localparam int LIMIT_CYCLES    = 1_000_000;
   localparam int SETTLE_CYCLES   = 16;   // longer than a down command, with margin
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 40;
   localparam logic [2:0]  OP_HIGHEST = 3'd7;       // ops above OP_SUBMIT are unused
   localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF; // released tracking id, slot -1

   typedef struct {
      logic [2:0]  op;
      logic [3:0]  slot;
      logic [15:0] x_pos;
      logic [15:0] y_pos;
      logic [4:0]  ev_type;
      logic [9:0]  ev_code;
      logic [31:0] ev_value;
   } touch_item_type;

   typedef struct {
      logic [9:0]  code;
      logic [31:0] value;
   } inject_entry_type;

   typedef struct {
      logic [4:0]  ev_type;
      logic [9:0]  code;
      logic [31:0] value;
   } frame_entry_type;

   // ---------------------------------------------------------------- DUT ports
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_op = OP_REAL;
   logic [3:0]         req_slot = '0;
   logic [15:0]        req_x_pos = '0;
   logic [15:0]        req_y_pos = '0;
   logic [4:0]         req_ev_type = '0;
   logic [9:0]         req_ev_code = '0;
   logic signed [31:0] req_ev_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [4:0]         rsp_out_type;
   logic [9:0]         rsp_out_code;
   logic signed [31:0] rsp_out_value;
   logic               rsp_last_of_run;
   logic               rsp_dropped_flag;
   logic               csr_wr_en = 1'b0;
   logic [3:0]         csr_wr_data = '0;

   // ---------------------------------------------------------- predictor state
   logic [3:0]        fwd_limit = '0;     // mirror of forward_slot_limit
   logic [15:0]       finger_down = '0;   // virtual slots currently touching
   int                cache_sel = -1;     // slot last selected in the inject cache, -1 none
   int                real_slot = 0;      // last slot selected by the real device
   inject_entry_type  inject_cache[$];
   frame_entry_type   frame_buf[$];
   bit                inject_lost = 1'b0;
   bit                frame_lost = 1'b0;

   rsp_item_type      expected_events[$]; // results still owed by the DUT, oldest first
   touch_item_type    touch_items[$];     // items waiting for the driver

   int             req_gap_pct = 0;    // chance per cycle that the sender idles
   int             rsp_stall_pct = 0;  // chance per cycle that the receiver stalls
   int             mismatches = 0;
   int             cycle_count = 0;

   multitouch_event_merger_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_slot         (req_slot),
      .req_x_pos        (req_x_pos),
      .req_y_pos        (req_y_pos),
      .req_ev_type      (req_ev_type),
      .req_ev_code      (req_ev_code),
      .req_ev_value     (req_ev_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_type     (rsp_out_type),
      .rsp_out_code     (rsp_out_code),
      .rsp_out_value    (rsp_out_value),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_dropped_flag (rsp_dropped_flag),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic void owe_event(logic [4:0] ev_type, logic [9:0] code, logic [31:0] value,
                                     logic last, logic drop);
      rsp_item_type e;
      e.out_type     = ev_type;
      e.out_code     = code;
      e.out_value    = value;
      e.last_of_run  = last;
      e.dropped_flag = drop;
      expected_events.insert(expected_events.size(), e);
   endfunction

   // Full cache: the event is lost but the overflow mark flags the next submit.
   function automatic void cache_event(logic [9:0] code, logic [31:0] value);
      inject_entry_type e;
      if (inject_cache.size() >= InjectDepthDefault) begin
         inject_lost = 1'b1;
      end else begin
         e.code  = code;
         e.value = value;
         inject_cache.insert(inject_cache.size(), e);
      end
   endfunction

   // Applies one accepted item to the mirrored state and queues the events it flushes.
   function automatic void merge_event_step(touch_item_type it);
      int               sl;
      logic             fwd;
      logic [15:0]      sel;
      frame_entry_type  fe;
      case (it.op)
         OP_REAL: begin
            fwd = 1'b1;
            if (it.ev_type == EV_ABS) begin
               if (it.ev_code == C_SLOT) real_slot = $signed(it.ev_value);
               // signed compare: a negative real slot is always forwarded
               if (real_slot > int'(fwd_limit)) fwd = 1'b0;
            end
            if (it.ev_type == EV_SYN && it.ev_code == C_REPORT) begin
               foreach (frame_buf[i])
                  owe_event(frame_buf[i].ev_type, frame_buf[i].code, frame_buf[i].value,
                            1'b0, frame_lost);
               owe_event(it.ev_type, it.ev_code, it.ev_value, 1'b1, frame_lost);
               frame_buf.delete();
               frame_lost = 1'b0;
            end else if (fwd || it.ev_type == EV_SYN) begin
               if (frame_buf.size() >= RealDepthDefault) begin
                  frame_lost = 1'b1;
               end else begin
                  fe.ev_type = it.ev_type;
                  fe.code    = it.ev_code;
                  fe.value   = it.ev_value;
                  frame_buf.insert(frame_buf.size(), fe);
               end
            end
         end
         OP_SUBMIT: begin
            if (inject_cache.size() != 0) begin
               foreach (inject_cache[i])
                  owe_event(EV_ABS, inject_cache[i].code, inject_cache[i].value, 1'b0,
                            inject_lost);
               owe_event(EV_SYN, C_REPORT, '0, 1'b0, inject_lost);
               owe_event(EV_ABS, C_SLOT, real_slot, 1'b0, inject_lost);
               owe_event(EV_SYN, C_REPORT, '0, 1'b1, inject_lost);
               cache_sel = (real_slot >= 0 && real_slot < TotalSlotsDefault) ? real_slot : -1;
               inject_cache.delete();
               inject_lost = 1'b0;
            end
         end
         OP_DOWN, OP_MOVE, OP_UP: begin
            sl = int'(fwd_limit) + int'(it.slot) + 1;
            if (sl < TotalSlotsDefault) begin
               sel = 16'd1 << sl;
               if (it.op == OP_DOWN) begin
                  if ((finger_down & sel) == '0) begin
                     cache_event(C_SLOT, sl);
                     cache_event(C_TRACK, sl + TrackingBaseDefault);
                     cache_event(C_PX, 32'(it.x_pos));
                     cache_event(C_PY, 32'(it.y_pos));
                     cache_sel = sl;
                     finger_down |= sel;
                  end
               end else if ((finger_down & sel) != '0) begin
                  // slot select only when the cache points elsewhere
                  if (it.op == OP_MOVE) begin
                     if (cache_sel != sl) begin
                        cache_event(C_SLOT, sl);
                        cache_sel = sl;
                     end
                     cache_event(C_PX, 32'(it.x_pos));
                     cache_event(C_PY, 32'(it.y_pos));
                  end else begin
                     if (cache_sel != sl) cache_event(C_SLOT, sl);
                     cache_event(C_TRACK, ALL_ONES);
                     cache_sel = -1;
                     finger_down &= ~sel;
                  end
               end
            end
         end
         default: ;  // unused ops do nothing
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic touch_item_type random_item();
      touch_item_type it;
      it.op       = 3'($urandom_range(OP_HIGHEST));
      it.slot     = 4'($urandom_range(15));
      it.x_pos    = 16'($urandom);
      it.y_pos    = 16'($urandom);
      it.ev_type  = 5'($urandom);
      it.ev_code  = 10'($urandom);
      it.ev_value = $urandom;
      return it;
   endfunction

   // Unused fields keep random content so the block is seen to ignore them.
   function automatic void add_real(logic [4:0] ev_type, logic [9:0] code, logic [31:0] value);
      touch_item_type it;
      it          = random_item();
      it.op       = OP_REAL;
      it.ev_type  = ev_type;
      it.ev_code  = code;
      it.ev_value = value;
      touch_items.insert(touch_items.size(), it);
   endfunction

   function automatic void add_touch(logic [2:0] op, logic [3:0] slot, logic [15:0] x,
                                     logic [15:0] y);
      touch_item_type it;
      it       = random_item();
      it.op    = op;
      it.slot  = slot;
      it.x_pos = x;
      it.y_pos = y;
      touch_items.insert(touch_items.size(), it);
   endfunction

   // Mostly valid slots, now and then -1 or an arbitrary 32-bit value.
   function automatic logic [31:0] pick_real_slot();
      case ($urandom_range(9))
         0:       return ALL_ONES;
         1:       return $urandom;
         default: return 32'($urandom_range(15));
      endcase
   endfunction

   task automatic write_limit(logic [3:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      fwd_limit    = value;
   endtask

   // Idle means: nothing queued or on the wire, nothing owed, then a settle pause
   // for commands that fill the cache without producing a result.
   task automatic wait_drained();
      do @(negedge clock);
      while (touch_items.size() != 0 || req_valid || expected_events.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------ driver
   // One request transfer per cycle at most. Valid stays up with a stable payload
   // until the transfer; the next item may follow in the same cycle.
   touch_item_type drive_item;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) merge_event_step(drive_item);
         if (!req_valid || req_ready) begin
            if (touch_items.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
               drive_item    = touch_items.pop_front();
               req_valid    <= 1'b1;
               req_op       <= drive_item.op;
               req_slot     <= drive_item.slot;
               req_x_pos    <= drive_item.x_pos;
               req_y_pos    <= drive_item.y_pos;
               req_ev_type  <= drive_item.ev_type;
               req_ev_code  <= drive_item.ev_code;
               req_ev_value <= drive_item.ev_value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ----------------------------------------------------------------- monitor
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               $error("unexpected result transfer: type %0d code %0d value %0h",
                      rsp_out_type, rsp_out_code, rsp_out_value);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_out_type !== want.out_type) begin
                  $error("out_type: expected %0d, got %0d", want.out_type, rsp_out_type);
                  mismatches++;
               end
               if (rsp_out_code !== want.out_code) begin
                  $error("out_code: expected %0d, got %0d", want.out_code, rsp_out_code);
                  mismatches++;
               end
               if (rsp_out_value !== want.out_value) begin
                  $error("out_value: expected %0h, got %0h", want.out_value, rsp_out_value);
                  mismatches++;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                         rsp_last_of_run);
                  mismatches++;
               end
               if (rsp_dropped_flag !== want.dropped_flag) begin
                  $error("dropped_flag: expected %0b, got %0b", want.dropped_flag,
                         rsp_dropped_flag);
                  mismatches++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ----------------------------------------------------------------- timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("FAIL multitouch_event_merger_core");
         $finish;
      end
   end

   // ------------------------------------------------------------------- test
   initial begin
      touch_item_type it;
      int          added;
      int          n0;
      int          pick;
      int          span;
      int          narrow;
      int          count;
      int          r;
      logic [3:0]  lim;
      logic [2:0]  op;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed pass, limit 0, so virtual slot = slot + 1.
      write_limit('0);
      add_real(EV_ABS, C_SLOT, '0);            // real slot 0, forwarded
      add_real(EV_ABS, C_PX, 32'h7FFF_FFFF);   // largest value
      add_real('1, '1, 32'h8000_0000);         // odd type and code, smallest value
      add_real(EV_SYN, C_PX, ALL_ONES);        // sync that is not a report: buffered
      add_real(EV_ABS, C_SLOT, ALL_ONES);      // negative slot still forwarded
      add_real(EV_ABS, C_SLOT, 32'd3);         // above the limit: dropped
      add_real(EV_ABS, C_PY, 32'd100);         // dropped with it
      add_real(EV_SYN, C_REPORT, '0);          // flushes the frame
      add_touch(OP_DOWN, 4'd0, '0, '1);
      add_touch(OP_DOWN, 4'd0, 16'd1, 16'd2);  // already down
      add_touch(OP_MOVE, 4'd0, '1, '0);        // slot select suppressed
      add_touch(OP_MOVE, 4'd2, 16'd5, 16'd6);  // slot not down
      add_touch(OP_DOWN, 4'd14, 16'($urandom), 16'($urandom));  // top virtual slot
      add_touch(OP_DOWN, 4'd15, 16'($urandom), 16'($urandom));  // out of range
      add_touch(OP_MOVE, 4'd0, 16'($urandom), 16'($urandom));   // select re-emitted
      add_touch(OP_UP, 4'd14, '0, '0);
      add_touch(OP_UP, 4'd14, '0, '0);         // already up
      for (int k = OP_SUBMIT + 1; k <= OP_HIGHEST; k++) begin
         it    = random_item();
         it.op = 3'(k);
         touch_items.insert(touch_items.size(), it);
      end
      add_touch(OP_SUBMIT, '0, '0, '0);        // real slot 3 restored
      add_touch(OP_SUBMIT, '0, '0, '0);        // empty cache: no results
      add_real(EV_ABS, C_SLOT, '0);
      add_touch(OP_UP, 4'd0, '0, '0);
      add_touch(OP_SUBMIT, '0, '0, '0);
      wait_drained();

      // Random phases: extremes of the limit first, idle pattern rotating per phase.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       lim = 4'd14;
            1:       lim = 4'd0;
            2:       lim = 4'd9;
            3:       lim = 4'd3;
            4:       lim = 4'($urandom_range(14));
            5:       lim = 4'd12;
            6:       lim = 4'd1;
            default: lim = 4'd14;
         endcase
         case (phase % 4)
            0: begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_gap_pct = 83; rsp_stall_pct = 0;  end
            2: begin req_gap_pct = 0;  rsp_stall_pct = 83; end
            default: begin req_gap_pct = 15; rsp_stall_pct = 15; end
         endcase
         write_limit(lim);
         span   = 14 - int'(fwd_limit);
         narrow = (span < 4) ? span : 4;
         added  = 0;
         while (added < ITEMS_PER_PHASE) begin
            n0   = touch_items.size();
            pick = $urandom_range(99);
            if (pick < 40) begin
               // real frame; now and then long enough to overflow the frame buffer
               count = ($urandom_range(9) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 6);
               if ($urandom_range(1)) add_real(EV_ABS, C_SLOT, pick_real_slot());
               for (int k = 0; k < count; k++) begin
                  r = $urandom_range(9);
                  if (r < 2)      add_real(EV_ABS, C_PX, $urandom);
                  else if (r < 4) add_real(EV_ABS, C_PY, $urandom);
                  else if (r < 5) add_real(EV_ABS, C_TRACK, $urandom);
                  else if (r < 6) add_real(EV_SYN, 10'($urandom_range(1, 1023)), $urandom);
                  else if (r < 7) add_real(5'($urandom), 10'($urandom), $urandom);
                  else            add_real(EV_ABS, C_SLOT, pick_real_slot());
               end
               add_real(EV_SYN, C_REPORT, $urandom);
            end else if (pick < 85) begin
               // burst of finger commands closed by a submit; long bursts overflow the cache
               count = ($urandom_range(7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
               for (int k = 0; k < count; k++) begin
                  r = $urandom_range(99);
                  op = (r < 40) ? OP_DOWN : (r < 75) ? OP_MOVE : OP_UP;
                  if ($urandom_range(9) == 0)
                     add_touch(op, 4'($urandom_range(15)), 16'($urandom), 16'($urandom));
                  else if (count > 8)
                     add_touch(op, 4'($urandom_range(span)), 16'($urandom), 16'($urandom));
                  else
                     add_touch(op, 4'($urandom_range(narrow)), 16'($urandom), 16'($urandom));
               end
               if ($urandom_range(9) != 0) add_touch(OP_SUBMIT, 4'($urandom), '0, '0);
            end else begin
               it = random_item();
               touch_items.insert(touch_items.size(), it);
               if (it.op > OP_SUBMIT) n0++;  // ignored items are not counted
            end
            added += touch_items.size() - n0;
         end
         wait_drained();
      end

      if (mismatches == 0)
         $display("PASS multitouch_event_merger_core");
      else
         $display("FAIL multitouch_event_merger_core");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/mtem_pkg.sv
rtl/mtem_ram.sv
rtl/mtem_out_reg.sv
rtl/multitouch_event_merger_core.sv
rtl/mtem_checker.sv
test/tb_top.sv
